### rtl/c8ie_pkg.sv
`timescale 1ns / 1ps

package c8ie_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam logic [SP_W-1:0] SP_MAX = SP_W'(STACK_DEPTH - 1);

  localparam logic [11:0] START_RST = 12'd512;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNIMPL  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // top nibble of the opcode
  localparam logic [3:0] OP_SYS     = 4'h0;
  localparam logic [3:0] OP_JP      = 4'h1;
  localparam logic [3:0] OP_CALL    = 4'h2;
  localparam logic [3:0] OP_SE_IMM  = 4'h3;
  localparam logic [3:0] OP_SNE_IMM = 4'h4;
  localparam logic [3:0] OP_SE_REG  = 4'h5;
  localparam logic [3:0] OP_LD_IMM  = 4'h6;
  localparam logic [3:0] OP_ADD_IMM = 4'h7;
  localparam logic [3:0] OP_ALU     = 4'h8;
  localparam logic [3:0] OP_SNE_REG = 4'h9;
  localparam logic [3:0] OP_LD_I    = 4'hA;
  localparam logic [3:0] OP_JP_V0   = 4'hB;
  localparam logic [3:0] OP_RND     = 4'hC;
  localparam logic [3:0] OP_DRW     = 4'hD;
  localparam logic [3:0] OP_KEY     = 4'hE;
  localparam logic [3:0] OP_MISC    = 4'hF;

  // low nibble of 8xyn
  localparam logic [3:0] ALU_LD   = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] KK_CLS  = 8'hE0;
  localparam logic [7:0] KK_RET  = 8'hEE;
  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;

  localparam logic [3:0] REG_V0 = 4'h0;
  localparam logic [3:0] REG_VF = 4'hF;

  localparam logic CFG_ADDR_START = 1'b0;

  typedef struct packed {
    logic       x_en;
    logic [3:0] x_addr;
    logic [7:0] x_data;
    logic       f_en;
    logic [7:0] f_data;
  } rf_wr_t;

  typedef struct packed {
    logic            en;
    logic [SP_W-1:0] addr;
    logic [11:0]     data;
  } stk_wr_t;

  typedef struct packed {
    logic [11:0]     pc;
    logic [1:0]      status;
    logic [11:0]     idx;
    logic [SP_W-1:0] sp;
    logic [7:0]      vx_after;
    logic [7:0]      vf_after;
    rf_wr_t          rf_wr;
    stk_wr_t         stk_wr;
  } exec_res_t;

endpackage

### rtl/c8ie_regfile.sv
`timescale 1ns / 1ps

module c8ie_regfile (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [3:0]        rd_x,
  input  logic [3:0]        rd_y,
  input  c8ie_pkg::rf_wr_t  wr,
  output logic [7:0]        vx,
  output logic [7:0]        vy,
  output logic [7:0]        v0,
  output logic [7:0]        vf
);
  import c8ie_pkg::*;

  logic [7:0]  mem [16];
  logic [15:0] vld_r;
  logic [7:0]  rdx_r, rdy_r;
  logic        rdx_vld_r, rdy_vld_r;
  logic [3:0]  rx_r, ry_r;
  logic        fwd_vld_r;
  logic [3:0]  fwd_addr_r;
  logic [7:0]  fwd_data_r;
  logic [7:0]  v0_r, vf_r;
  logic        mem_we;
  logic [7:0]  mx, my;

  // VF lives in its own flop so that Vx and the flag can land in the same cycle
  assign mem_we = wr.x_en && (wr.x_addr != REG_VF);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr.x_addr] <= wr.x_data;
    end
    if (rd_en) begin
      rdx_r <= mem[rd_x];
      rdy_r <= mem[rd_y];
      rdx_vld_r <= vld_r[rd_x];
      rdy_vld_r <= vld_r[rd_y];
      rx_r <= rd_x;
      ry_r <= rd_y;
    end
    if (mem_we) begin
      fwd_addr_r <= wr.x_addr;
      fwd_data_r <= wr.x_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      fwd_vld_r <= 1'b0;
      v0_r <= '0;
      vf_r <= '0;
    end else begin
      if (mem_we) begin
        vld_r[wr.x_addr] <= 1'b1;
        fwd_vld_r <= 1'b1;
      end
      if (wr.x_en && wr.x_addr == REG_V0) begin
        v0_r <= wr.x_data;
      end
      if (wr.f_en) begin
        vf_r <= wr.f_data;
      end else if (wr.x_en && wr.x_addr == REG_VF) begin
        vf_r <= wr.x_data;
      end
    end
  end

  // the most recent write covers one that landed on the read edge
  always_comb begin
    if (fwd_vld_r && fwd_addr_r == rx_r) mx = fwd_data_r;
    else if (rdx_vld_r)                   mx = rdx_r;
    else                                  mx = '0;
    if (fwd_vld_r && fwd_addr_r == ry_r) my = fwd_data_r;
    else if (rdy_vld_r)                   my = rdy_r;
    else                                  my = '0;
  end

  assign vx = (rx_r == REG_VF) ? vf_r : (rx_r == REG_V0) ? v0_r : mx;
  assign vy = (ry_r == REG_VF) ? vf_r : (ry_r == REG_V0) ? v0_r : my;
  assign v0 = v0_r;
  assign vf = vf_r;

endmodule

### rtl/c8ie_stack.sv
`timescale 1ns / 1ps

module c8ie_stack (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [c8ie_pkg::SP_W-1:0]    rd_addr,
  input  c8ie_pkg::stk_wr_t            wr,
  output logic [11:0]                  rd_data
);
  import c8ie_pkg::*;

  logic [11:0]            mem [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] vld_r;
  logic [11:0]            rd_r;
  logic                   rd_vld_r;
  logic [SP_W-1:0]        ra_r;
  logic                   fwd_vld_r;
  logic [SP_W-1:0]        fwd_addr_r;
  logic [11:0]            fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
      fwd_addr_r <= wr.addr;
      fwd_data_r <= wr.data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
      ra_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      fwd_vld_r <= 1'b0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
      fwd_vld_r <= 1'b1;
    end
  end

  always_comb begin
    if (fwd_vld_r && fwd_addr_r == ra_r) rd_data = fwd_data_r;
    else if (rd_vld_r)                   rd_data = rd_r;
    else                                 rd_data = '0;
  end

endmodule

### rtl/c8ie_exec.sv
`timescale 1ns / 1ps

module c8ie_exec (
  input  logic [15:0]                instr,
  input  logic [7:0]                 key,
  input  logic [7:0]                 rnd,
  input  logic [7:0]                 vx,
  input  logic [7:0]                 vy,
  input  logic [7:0]                 v0,
  input  logic [7:0]                 vf,
  input  logic [11:0]                pc,
  input  logic [11:0]                idx,
  input  logic [c8ie_pkg::SP_W-1:0]  sp,
  input  logic [11:0]                stk_top,
  output c8ie_pkg::exec_res_t        res
);
  import c8ie_pkg::*;

  logic [3:0]      op_top, x, n;
  logic [7:0]      kk;
  logic [11:0]     nnn, pc_plus2;
  logic [8:0]      sum;
  logic [7:0]      diff;
  logic            skip;
  logic [SP_W-1:0] sp_inc, sp_dec;

  assign op_top   = instr[15:12];
  assign x        = instr[11:8];
  assign n        = instr[3:0];
  assign kk       = instr[7:0];
  assign nnn      = instr[11:0];
  assign pc_plus2 = pc + 12'd2;
  assign sp_inc   = (sp == SP_MAX) ? '0 : sp + 1'b1;
  assign sp_dec   = (sp == '0) ? SP_MAX : sp - 1'b1;

  always_comb begin
    sum  = '0;
    diff = '0;
    skip = 1'b0;
    res  = '0;
    res.pc = pc_plus2;
    res.status = ST_OK;
    res.idx = idx;
    res.sp = sp;
    res.rf_wr.x_addr = x;

    case (op_top)
      OP_SYS: begin
        if (kk == KK_CLS && x == 4'h0) begin
          res.status = ST_UNIMPL;
        end else if (kk == KK_RET && x == 4'h0) begin
          res.pc = stk_top;
          res.sp = sp_dec;
        end else begin
          res.status = ST_INVALID;
        end
      end
      OP_JP: res.pc = nnn;
      OP_CALL: begin
        res.sp = sp_inc;
        res.stk_wr.en = 1'b1;
        res.stk_wr.addr = sp_inc;
        res.stk_wr.data = pc_plus2;
        res.pc = nnn;
      end
      OP_SE_IMM:  skip = (vx == kk);
      OP_SNE_IMM: skip = (vx != kk);
      OP_SE_REG:  skip = (vx == vy);
      OP_SNE_REG: skip = (vx != vy);
      OP_LD_IMM: begin
        res.rf_wr.x_en = 1'b1;
        res.rf_wr.x_data = kk;
      end
      OP_ADD_IMM: begin
        res.rf_wr.x_en = 1'b1;
        res.rf_wr.x_data = vx + kk;
      end
      OP_ALU: begin
        res.rf_wr.x_en = 1'b1;
        case (n)
          ALU_LD:  res.rf_wr.x_data = vy;
          ALU_OR:  res.rf_wr.x_data = vx | vy;
          ALU_AND: res.rf_wr.x_data = vx & vy;
          ALU_XOR: res.rf_wr.x_data = vx ^ vy;
          ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            res.rf_wr.x_data = sum[7:0];
            res.rf_wr.f_en = 1'b1;
            res.rf_wr.f_data = {7'd0, sum[8]};
          end
          ALU_SUB: begin
            diff = vx - vy;
            res.rf_wr.x_data = diff;
            res.rf_wr.f_en = 1'b1;
            res.rf_wr.f_data = {7'd0, vx > vy};
          end
          ALU_SUBN: begin
            diff = vy - vx;
            res.rf_wr.x_data = diff;
            res.rf_wr.f_en = 1'b1;
            res.rf_wr.f_data = {7'd0, vy > vx};
          end
          ALU_SHR: begin
            res.rf_wr.x_data = {1'b0, vx[7:1]};
            res.rf_wr.f_en = 1'b1;
            res.rf_wr.f_data = {7'd0, vx[0]};
          end
          ALU_SHL: begin
            res.rf_wr.x_data = {vx[6:0], 1'b0};
            res.rf_wr.f_en = 1'b1;
            res.rf_wr.f_data = {7'd0, vx[7]};
          end
          default: begin
            res.rf_wr.x_en = 1'b0;
            res.status = ST_INVALID;
          end
        endcase
      end
      OP_LD_I:  res.idx = nnn;
      OP_JP_V0: res.pc = nnn + {4'd0, v0};
      OP_RND: begin
        res.rf_wr.x_en = 1'b1;
        res.rf_wr.x_data = rnd & kk;
      end
      OP_DRW:  res.status = ST_UNIMPL;
      OP_KEY: begin
        if (kk == KK_SKP)       skip = (key == vx);
        else if (kk == KK_SKNP) skip = (key != vx);
        else                    res.status = ST_INVALID;
      end
      OP_MISC: res.status = ST_UNIMPL;
      default: res.status = ST_UNIMPL;
    endcase

    if (skip) res.pc = pc_plus2 + 12'd2;

    // flag is written after Vx, so it wins when x is VF
    if (res.rf_wr.f_en)                              res.vf_after = res.rf_wr.f_data;
    else if (res.rf_wr.x_en && x == REG_VF)          res.vf_after = res.rf_wr.x_data;
    else                                             res.vf_after = vf;
    if (x == REG_VF)          res.vx_after = res.vf_after;
    else if (res.rf_wr.x_en)  res.vx_after = res.rf_wr.x_data;
    else                      res.vx_after = vx;
  end

endmodule

### rtl/chip8_instruction_execute.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    tdata: instruction, pressed_key, random_byte
// out_     out  out_tvalid/out_tready  tdata: next_pc, status, vx_value, vf_value, index
// cfg_     in   APB psel/penable       start_address at byte address 0
//
// One instruction per cycle sustained while out_tready stays high; a taken beat waits in the
// execute stage register (s1) and its result is registered in the output register for out_.
// Register file and return stack reads issue on the input beat; the write of the instruction
// ahead lands on the same edge and is forwarded.
// Reset: PC loads 512, stack pointer, I and all V registers and stack entries read as zero
// (per-entry valid bits, no clearing pass).
// A stalled output holds the execute stage; input keeps flowing while either stage can move.

module chip8_instruction_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] instruction, [23:16] pressed_key, [31:24] random_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [11:0] next_pc, [13:12] status, [21:14] vx_value,
                                  // [29:22] vf_value, [41:30] index_value, [47:42] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import c8ie_pkg::*;

  logic            s1_vld_r;
  logic [31:0]     s1_data_r;
  logic            out_vld_r;
  logic [47:0]     out_data_r;
  logic [11:0]     pc_r, idx_r, start_r;
  logic [SP_W-1:0] sp_r, stk_ra;
  logic            s1_fire, in_acc, cfg_wr;
  logic [7:0]      vx, vy, v0, vf;
  logic [11:0]     stk_top;
  exec_res_t       ex;
  rf_wr_t          rf_wr;
  stk_wr_t         stk_wr;

  assign s1_fire   = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_fire;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign rf_wr  = s1_fire ? ex.rf_wr : '0;
  assign stk_wr = s1_fire ? ex.stk_wr : '0;
  // the stack read for the next beat must see the pointer as left by this one
  assign stk_ra = s1_fire ? ex.sp : sp_r;

  c8ie_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_acc),
    .rd_x  (in_tdata[11:8]),
    .rd_y  (in_tdata[7:4]),
    .wr    (rf_wr),
    .vx    (vx),
    .vy    (vy),
    .v0    (v0),
    .vf    (vf)
  );

  c8ie_stack u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (stk_ra),
    .wr      (stk_wr),
    .rd_data (stk_top)
  );

  c8ie_exec u_exec (
    .instr   (s1_data_r[15:0]),
    .key     (s1_data_r[23:16]),
    .rnd     (s1_data_r[31:24]),
    .vx      (vx),
    .vy      (vy),
    .v0      (v0),
    .vf      (vf),
    .pc      (pc_r),
    .idx     (idx_r),
    .sp      (sp_r),
    .stk_top (stk_top),
    .res     (ex)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_tdata;
    end
    if (s1_fire) begin
      out_data_r <= {6'd0, ex.idx, ex.vf_after, ex.vx_after, ex.status, ex.pc};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r <= START_RST;
      start_r <= START_RST;
      idx_r <= '0;
      sp_r <= '0;
    end else begin
      if (in_acc)       s1_vld_r <= 1'b1;
      else if (s1_fire) s1_vld_r <= 1'b0;
      if (s1_fire)         out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
      if (s1_fire) begin
        pc_r <= ex.pc;
        idx_r <= ex.idx;
        sp_r <= ex.sp;
      end
      if (cfg_wr && cfg_paddr == CFG_ADDR_START) begin
        start_r <= cfg_pwdata[11:0];
        pc_r <= cfg_pwdata[11:0];
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_START) ? {20'd0, start_r} : 32'd0;

  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_vld_r)
    else $error("executed beat did not reach the output register");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_fire) |=> (s1_vld_r && $stable(s1_data_r)))
    else $error("stalled execute stage lost its instruction");

  a_fault_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && ex.status != ST_OK) |-> (ex.pc == pc_r + 12'd2 && !ex.rf_wr.x_en
                                         && !ex.stk_wr.en && ex.sp == sp_r))
    else $error("faulting instruction changed state beyond the PC advance");

  a_sp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && ex.sp != sp_r) |-> (ex.stk_wr.en || s1_data_r[15:12] == OP_SYS))
    else $error("stack pointer moved outside call or return");

endmodule

### dv/tb_chip8_instruction_execute.sv
`timescale 1ns / 1ps

module tb_chip8_instruction_execute;
  import c8ie_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 102;

  typedef struct packed {
    logic [11:0] next_pc;
    logic [1:0]  status;
    logic [7:0]  vx_value;
    logic [7:0]  vf_value;
    logic [11:0] index_value;
  } exec_result_t;

  // Tracks the architectural state and queues the result expected for each instruction.
  class exec_tracker;
    logic [7:0]      vreg [16];
    logic [11:0]     ret_stack [STACK_DEPTH];
    logic [11:0]     idx;
    logic [11:0]     pc;
    logic [11:0]     start_addr;
    logic [SP_W-1:0] sp;
    exec_result_t    pending_results [$];
    int              mismatches;

    function new();
      foreach (vreg[i]) vreg[i] = '0;
      foreach (ret_stack[i]) ret_stack[i] = '0;
      idx = '0;
      sp = '0;
      start_addr = START_RST;
      pc = START_RST;
      mismatches = 0;
    endfunction

    function void load_start(logic [11:0] addr);
      start_addr = addr;
      pc = addr;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_instruction(logic [15:0] op, logic [7:0] key, logic [7:0] rnd);
      logic [3:0]   x, y, n;
      logic [7:0]   kk, vx, vy;
      logic [11:0]  nnn;
      logic [8:0]   sum;
      logic         skip;
      exec_result_t r;
      x = op[11:8];
      y = op[7:4];
      n = op[3:0];
      kk = op[7:0];
      nnn = op[11:0];
      vx = vreg[x];
      vy = vreg[y];
      skip = 1'b0;
      r.status = ST_OK;
      pc = pc + 12'd2;
      case (op[15:12])
        OP_SYS: begin
          if (kk == KK_CLS && x == '0) r.status = ST_UNIMPL;
          else if (kk == KK_RET && x == '0) begin
            pc = ret_stack[sp];
            sp = sp - 1'b1;
          end else r.status = ST_INVALID;
        end
        OP_JP: pc = nnn;
        OP_CALL: begin
          sp = sp + 1'b1;
          ret_stack[sp] = pc;
          pc = nnn;
        end
        OP_SE_IMM:  skip = (vx == kk);
        OP_SNE_IMM: skip = (vx != kk);
        OP_SE_REG:  skip = (vx == vy);
        OP_LD_IMM:  vreg[x] = kk;
        OP_ADD_IMM: vreg[x] = vx + kk;
        OP_ALU: begin
          // flag is written after Vx so it wins when x is VF
          case (n)
            ALU_LD:  vreg[x] = vy;
            ALU_OR:  vreg[x] = vx | vy;
            ALU_AND: vreg[x] = vx & vy;
            ALU_XOR: vreg[x] = vx ^ vy;
            ALU_ADD: begin
              sum = {1'b0, vx} + {1'b0, vy};
              vreg[x] = sum[7:0];
              vreg[REG_VF] = {7'b0, sum[8]};
            end
            ALU_SUB: begin
              vreg[x] = vx - vy;
              vreg[REG_VF] = {7'b0, vx > vy};
            end
            ALU_SHR: begin
              vreg[x] = vx >> 1;
              vreg[REG_VF] = {7'b0, vx[0]};
            end
            ALU_SUBN: begin
              vreg[x] = vy - vx;
              vreg[REG_VF] = {7'b0, vy > vx};
            end
            ALU_SHL: begin
              vreg[x] = vx << 1;
              vreg[REG_VF] = {7'b0, vx[7]};
            end
            default: r.status = ST_INVALID;
          endcase
        end
        OP_SNE_REG: skip = (vx != vy);
        OP_LD_I:    idx = nnn;
        OP_JP_V0:   pc = nnn + {4'b0, vreg[REG_V0]};
        OP_RND:     vreg[x] = rnd & kk;
        OP_DRW:     r.status = ST_UNIMPL;
        OP_KEY: begin
          if (kk == KK_SKP) skip = (key == vx);
          else if (kk == KK_SKNP) skip = (key != vx);
          else r.status = ST_INVALID;
        end
        default: r.status = ST_UNIMPL;
      endcase
      if (skip) pc = pc + 12'd2;
      r.next_pc = pc;
      r.vx_value = vreg[x];
      r.vf_value = vreg[REG_VF];
      r.index_value = idx;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [47:0] d);
      exec_result_t e;
      if (pending_results.size() == 0) begin
        $error("result beat with no instruction outstanding: %h", d);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      if (d[11:0] !== e.next_pc) begin
        $error("next_pc: expected %0h, got %0h", e.next_pc, d[11:0]);
        mismatches++;
      end
      if (d[13:12] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, d[13:12]);
        mismatches++;
      end
      if (d[21:14] !== e.vx_value) begin
        $error("vx_value: expected %0h, got %0h", e.vx_value, d[21:14]);
        mismatches++;
      end
      if (d[29:22] !== e.vf_value) begin
        $error("vf_value: expected %0h, got %0h", e.vf_value, d[29:22]);
        mismatches++;
      end
      if (d[41:30] !== e.index_value) begin
        $error("index_value: expected %0h, got %0h", e.index_value, d[41:30]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] instruction, [23:16] pressed_key, [31:24] random_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [11:0] next_pc, [13:12] status, [21:14] vx_value,
                           // [29:22] vf_value, [41:30] index_value, [47:42] zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [0:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  exec_tracker trk = new();
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles = 0;

  logic [3:0] alu_codes [9] = '{ALU_LD, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                                ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL};

  chip8_instruction_execute DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no beat on either channel for too long means the block has hung
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check each beat, then pick readiness for the next cycle
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) trk.check_result(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic [15:0] op, input logic [7:0] key,
                           input logic [7:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {rnd, key, op};
    do @(posedge clk); while (!in_tready);
    trk.note_instruction(op, key, rnd);
  endtask

  task automatic send_random();
    logic [3:0]  top, x, y;
    logic [7:0]  kk, key, rnd;
    logic [15:0] op;
    top = 4'($urandom_range(15));
    x = 4'($urandom_range(15));
    y = 4'($urandom_range(15));
    kk = 8'($urandom_range(255));
    key = 8'($urandom_range(255));
    rnd = 8'($urandom_range(255));
    case (top)
      OP_SYS: begin
        case ($urandom_range(3))
          0, 1: op = {OP_SYS, 4'h0, KK_RET};
          2: op = {OP_SYS, 4'h0, KK_CLS};
          default: op = {OP_SYS, x, kk};
        endcase
      end
      OP_SE_IMM, OP_SNE_IMM: begin
        if ($urandom_range(1)) kk = trk.vreg[x];
        op = {top, x, kk};
      end
      OP_SE_REG, OP_SNE_REG: begin
        if ($urandom_range(3) == 0) y = x;
        op = {top, x, y, kk[3:0]};
      end
      OP_ALU: begin
        if ($urandom_range(9) != 0) op = {OP_ALU, x, y, alu_codes[4'($urandom_range(8))]};
        else op = {OP_ALU, x, kk};
      end
      OP_KEY: begin
        case ($urandom_range(9))
          0: op = {OP_KEY, x, kk};
          1, 2, 3, 4: op = {OP_KEY, x, KK_SKP};
          default: op = {OP_KEY, x, KK_SKNP};
        endcase
        if ($urandom_range(1)) key = trk.vreg[x];
      end
      default: op = {top, x, kk};
    endcase
    if ($urandom_range(19) == 0) op = 16'($urandom);
    send_item(op, key, rnd);
  endtask

  // every beat returns one result, so an empty queue means the block is idle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_START;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    trk.load_start(data[11:0]);
  endtask

  task automatic run_directed();
    send_item({OP_SYS, 4'h0, KK_RET}, 8'h00, 8'h00);     // return on an empty stack
    send_item({OP_LD_IMM, 4'hA, 8'hFF}, 8'hFF, 8'hFF);
    send_item({OP_ADD_IMM, 4'hA, 8'h01}, 8'h00, 8'h00);  // wraps to zero
    send_item({OP_LD_IMM, 4'hB, 8'h80}, 8'h00, 8'h00);
    send_item({OP_LD_IMM, 4'hC, 8'hFF}, 8'h00, 8'h00);
    send_item({OP_ALU, 4'hB, 4'hC, ALU_ADD}, 8'h00, 8'h00);
    send_item({OP_ALU, 4'hC, 4'hB, ALU_SUB}, 8'h00, 8'h00);
    send_item({OP_ALU, 4'hC, 4'hC, ALU_SUB}, 8'h00, 8'h00); // equal operands, no flag
    send_item({OP_ALU, 4'hB, 4'hC, ALU_SUBN}, 8'h00, 8'h00);
    send_item({OP_LD_IMM, REG_VF, 8'h81}, 8'h00, 8'h00);
    send_item({OP_ALU, REG_VF, 4'h0, ALU_SHL}, 8'h00, 8'h00); // flag beats result in VF
    send_item({OP_ALU, 4'hC, 4'hB, ALU_SHR}, 8'h00, 8'h00);
    send_item({OP_ALU, 4'h1, 4'hC, ALU_OR}, 8'h00, 8'h00);
    send_item({OP_ALU, 4'h1, 4'hB, ALU_AND}, 8'h00, 8'h00);
    send_item({OP_ALU, 4'h2, 4'hC, ALU_XOR}, 8'h00, 8'h00);
    send_item({OP_ALU, 4'h3, 4'hC, ALU_LD}, 8'h00, 8'h00);
    send_item({OP_ALU, 4'h1, 4'h2, 4'h8}, 8'h00, 8'h00);  // unassigned ALU codes
    send_item({OP_ALU, 4'h1, 4'h2, 4'hF}, 8'h00, 8'h00);
    send_item({OP_LD_I, 12'hFFF}, 8'h00, 8'h00);
    send_item({OP_LD_IMM, REG_V0, 8'hFF}, 8'h00, 8'h00);
    send_item({OP_JP_V0, 12'hFFF}, 8'h00, 8'h00);         // target wraps past 4095
    send_item({OP_CALL, 12'hABC}, 8'h00, 8'h00);
    send_item({OP_SYS, 4'h0, KK_RET}, 8'h00, 8'h00);
    send_item({OP_SE_IMM, 4'hA, 8'h00}, 8'h00, 8'h00);
    send_item({OP_SNE_IMM, 4'hA, 8'h00}, 8'h00, 8'h00);
    send_item({OP_SE_REG, 4'hA, 4'hB, 4'h7}, 8'h00, 8'h00); // any low nibble accepted
    send_item({OP_SNE_REG, 4'hA, 4'hB, 4'hF}, 8'h00, 8'h00);
    send_item({OP_RND, 4'hD, 8'hF0}, 8'h00, 8'hA5);
    send_item({OP_KEY, 4'hA, KK_SKP}, 8'h00, 8'h00);
    send_item({OP_KEY, 4'hA, KK_SKNP}, 8'hFF, 8'h00);
    send_item({OP_KEY, 4'h1, 8'hFF}, 8'h00, 8'h00);
    send_item({OP_SYS, 4'h0, KK_CLS}, 8'h00, 8'h00);
    send_item({OP_SYS, 4'h1, 8'h23}, 8'h00, 8'h00);
    send_item({OP_DRW, 12'h123}, 8'h00, 8'h00);
    send_item({OP_MISC, 12'hFFF}, 8'h00, 8'h00);
    send_item({OP_JP, 12'h000}, 8'h00, 8'h00);
  endtask

  initial begin
    logic [11:0] start_val;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      case (ph)
        0: start_val = 12'hFFE;   // first advance wraps to zero
        1: start_val = 12'h000;
        2: start_val = 12'hFFF;
        4: start_val = START_RST;
        default: start_val = 12'($urandom_range(4095));
      endcase
      drain();
      cfg_write({20'($urandom_range(1048575)), start_val});
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random();
    end

    drain();
    repeat (8) @(posedge clk);
    if (trk.mismatches == 0 && trk.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
rtl/c8ie_pkg.sv
rtl/c8ie_regfile.sv
rtl/c8ie_stack.sv
rtl/c8ie_exec.sv
rtl/chip8_instruction_execute.sv
dv/tb_chip8_instruction_execute.sv
